/* design/r64e_pkg.sv */
// Shared types and constants for the rANS64 encoder step core.
package r64e_pkg;

    localparam int STATE_W = 64;
    localparam int WORD_W  = 32;
    localparam int FREQ_W  = 32;
    localparam int START_W = 31;
    localparam int SCALE_W = 5;
    localparam int ADDR_W  = 3;

    // request opcodes
    localparam logic [1:0] OP_ENCODE  = 2'd0;
    localparam logic [1:0] OP_FLUSH   = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;

    // register indexes, taken from paddr[2]
    localparam logic REG_SCALE = 1'b0;
    localparam logic REG_LB    = 1'b1;

    localparam logic [SCALE_W-1:0] SCALE_RESET = 5'd16;
    localparam logic [WORD_W-1:0]  LB_RESET    = 32'h8000_0000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_CMP,
        ST_DIV,
        ST_ADD,
        ST_UPD,
        ST_FLUSH_HI,
        ST_FLUSH_LO
    } enc_state_t;

endpackage

/* design/r64e_serdiv.sv */
// Bit-serial restoring divider: 64-bit dividend by 32-bit divisor, one quotient bit a cycle.
module r64e_serdiv (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [r64e_pkg::STATE_W-1:0]     dividend,
    input  logic [r64e_pkg::FREQ_W-1:0]      divisor,
    output logic                             done,
    output logic [r64e_pkg::STATE_W-1:0]     quotient,
    output logic [r64e_pkg::FREQ_W-1:0]      remainder
);
    import r64e_pkg::*;

    localparam int CNT_W = $clog2(STATE_W);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [STATE_W-1:0]    sh_reg;      // dividend bits out at the top, quotient bits in below
    logic [FREQ_W-1:0]     rem_reg;
    logic [FREQ_W-1:0]     div_reg;

    logic [FREQ_W:0]       r_sh;
    logic [FREQ_W:0]       diff;
    logic                  ge;

    assign r_sh = {rem_reg, sh_reg[STATE_W-1]};
    assign diff = r_sh - {1'b0, div_reg};
    // partial remainder stays below twice the divisor, so bit 32 is the borrow
    assign ge   = ~diff[FREQ_W];

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(STATE_W - 1);
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            sh_reg  <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            sh_reg  <= {sh_reg[STATE_W-2:0], ge};
            rem_reg <= ge ? diff[FREQ_W-1:0] : r_sh[FREQ_W-1:0];
        end
    end

    assign done      = done_reg;
    assign quotient  = sh_reg;
    assign remainder = rem_reg;

endmodule

/* design/rans64_encoder_step_core.sv */
// Top level of the rANS64 encoder step core: control, coder state, output register.
//
// Holds a 64-bit rANS coder state and takes one request at a time on the s_ side.
// Encode (opcode 0) compares the state's high word with the low word of
// sym_freq * (floor >> prob_scale_bits), floor being the state floor register; if
// the state is at or above that bound the low state word goes out as one word with
// tlast set and the state drops by 32 bits. The state then becomes
// ((x / freq) << scale) + start + x % freq, the division run by a bit-serial
// restoring divider at one quotient bit per cycle.
// After acceptance an encode runs through the bound multiply, the compare (which
// waits for a free output slot when a word goes out), the divider's 64 steps and
// its done strobe, the add of start and remainder, and the shift and write of the
// state before tready returns. Flush (opcode 1) sends the high word, then the low
// word with tlast, one per free output slot, leaving the state as is. Restart
// (opcode 2) loads the state floor into the state in the accepting cycle. Opcode 3
// and an encode with sym_freq zero are dropped. A finished word waits in the
// output register while the next request is taken. Registers (APB, pready tied
// high): 0x0 prob_scale_bits [4:0], 0x4 state floor [31:0]; paddr[1:0] is ignored.
// Write them only while the core is idle.
module rans64_encoder_step_core (
    input  logic                            clk,
    input  logic                            rst_n,
    // request stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [63:0]                     s_tdata,   // [31:0] sym_freq, [62:32] sym_start, [63] zero
    input  logic [1:0]                      s_tuser,   // [1:0] opcode
    // output word stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [r64e_pkg::WORD_W-1:0]     m_tdata,   // [31:0] out_word
    output logic                            m_tlast,   // is_last
    // configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [r64e_pkg::ADDR_W-1:0]     paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import r64e_pkg::*;

    enc_state_t             state_reg, state_next;

    // configuration
    logic [SCALE_W-1:0]     scale_reg;
    logic [WORD_W-1:0]      lb_reg;

    // coder state and request payload
    logic [STATE_W-1:0]     coder_reg;
    logic [FREQ_W-1:0]      freq_reg;
    logic [START_W-1:0]     start_reg;
    logic [WORD_W-1:0]      bound_reg;     // high word of the renormalisation bound
    logic [FREQ_W:0]        addend_reg;    // start + remainder

    // output register
    logic                   m_valid_reg;
    logic [WORD_W-1:0]      m_data_reg;
    logic                   m_last_reg;

    // control from the output decode
    logic                   accept;
    logic                   restart_load;
    logic                   load_out;
    logic [WORD_W-1:0]      out_word_d;
    logic                   out_last_d;
    logic                   div_start;

    logic                   slot_free;
    logic                   renorm;
    logic                   cfg_wr;
    logic [WORD_W-1:0]      lb_shifted;
    logic [WORD_W-1:0]      bound_lo;
    logic [STATE_W-1:0]     div_dividend;
    logic                   div_done;
    logic [STATE_W-1:0]     div_quo;
    logic [FREQ_W-1:0]      div_rem;

    assign slot_free  = ~m_valid_reg | m_tready;
    assign renorm     = (coder_reg[STATE_W-1:WORD_W] >= bound_reg);
    assign lb_shifted = lb_reg >> scale_reg;
    // only the low product word matters: the bound is that word shifted up by 32
    assign bound_lo   = freq_reg * lb_shifted;
    assign div_dividend = renorm ? {{WORD_W{1'b0}}, coder_reg[STATE_W-1:WORD_W]} : coder_reg;

    // ---------------- next state ----------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    case (s_tuser)
                        OP_ENCODE:
                        begin
                            if (s_tdata[FREQ_W-1:0] != '0)
                                state_next = ST_MUL;
                        end
                        OP_FLUSH: state_next = ST_FLUSH_HI;
                        default:  state_next = ST_IDLE;
                    endcase
                end
            end
            ST_MUL: state_next = ST_CMP;
            ST_CMP:
            begin
                if (!renorm || slot_free)
                    state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                    state_next = ST_ADD;
            end
            ST_ADD: state_next = ST_UPD;
            ST_UPD: state_next = ST_IDLE;
            ST_FLUSH_HI:
            begin
                if (slot_free)
                    state_next = ST_FLUSH_LO;
            end
            ST_FLUSH_LO:
            begin
                if (slot_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // ---------------- outputs of the sequencer ----------------
    always_comb
    begin
        s_tready     = 1'b0;
        restart_load = 1'b0;
        load_out     = 1'b0;
        out_word_d   = coder_reg[WORD_W-1:0];
        out_last_d   = 1'b1;
        div_start    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready     = 1'b1;
                restart_load = s_tvalid & (s_tuser == OP_RESTART);
            end
            ST_CMP:
            begin
                if (!renorm || slot_free)
                begin
                    div_start = 1'b1;
                    load_out  = renorm;
                end
            end
            ST_FLUSH_HI:
            begin
                load_out   = slot_free;
                out_word_d = coder_reg[STATE_W-1:WORD_W];
                out_last_d = 1'b0;
            end
            ST_FLUSH_LO:
            begin
                load_out = slot_free;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    assign accept = s_tvalid & s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // ---------------- coder state ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            coder_reg <= {{WORD_W{1'b0}}, LB_RESET};
        else if (restart_load)
            coder_reg <= {{WORD_W{1'b0}}, lb_reg};
        else if (state_reg == ST_UPD)
            coder_reg <= (div_quo << scale_reg) + {{(STATE_W-FREQ_W-1){1'b0}}, addend_reg};
    end

    // request payload and datapath registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            freq_reg  <= s_tdata[FREQ_W-1:0];
            start_reg <= s_tdata[FREQ_W+START_W-1:FREQ_W];
        end
        if (state_reg == ST_MUL)
            bound_reg <= bound_lo;
        if (state_reg == ST_ADD)
            addend_reg <= {{(FREQ_W-START_W+1){1'b0}}, start_reg} + {1'b0, div_rem};
    end

    r64e_serdiv u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (freq_reg),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // ---------------- output register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (load_out)
            m_valid_reg <= 1'b1;
        else if (m_tready)
            m_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            m_data_reg <= out_word_d;
            m_last_reg <= out_last_d;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg <= SCALE_RESET;
            lb_reg    <= LB_RESET;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == REG_SCALE)
                scale_reg <= pwdata[SCALE_W-1:0];
            else
                lb_reg <= pwdata[WORD_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_LB) ? lb_reg : {{(32-SCALE_W){1'b0}}, scale_reg};

endmodule

/* verif/tb_top.sv */
// Self-checking testbench for the rANS64 encoder step core.
`timescale 1ns / 100ps

module tb_top;

    import r64e_pkg::*;

    // opcode 3 has no name in the package; the core drops it
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // register byte addresses, index in paddr[2]
    localparam logic [ADDR_W-1:0] ADDR_SCALE = {REG_SCALE, 2'b00};
    localparam logic [ADDR_W-1:0] ADDR_LB    = {REG_LB, 2'b00};

    // cycles to let an encode that emits nothing run out before touching registers
    localparam int SETTLE_CYCLES = 80;

    // length of the long receiver hold-off
    localparam int HOLD_CYCLES = 400;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              last;
    } emitted_word_t;

    logic                clk      = 1'b0;
    logic                rst_n    = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [63:0]         s_tdata  = '0;   // [31:0] sym_freq, [62:32] sym_start, [63] zero
    logic [1:0]          s_tuser  = '0;   // [1:0] opcode
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [WORD_W-1:0]   m_tdata;         // [31:0] out_word
    logic                m_tlast;         // is_last
    logic                psel     = 1'b0;
    logic                penable  = 1'b0;
    logic                pwrite   = 1'b0;
    logic [ADDR_W-1:0]   paddr    = '0;
    logic [31:0]         pwdata   = '0;
    logic [31:0]         prdata;
    logic                pready;

    // shadow copy of the core's state and registers
    logic [STATE_W-1:0]  shadow_state = {32'd0, LB_RESET};
    logic [SCALE_W-1:0]  shadow_scale = SCALE_RESET;
    logic [WORD_W-1:0]   shadow_lb    = LB_RESET;

    emitted_word_t       pending_words[$];
    int                  fail_count    = 0;
    int unsigned         src_idle_pct  = 0;
    int unsigned         sink_stall_pct = 0;
    int                  hold_requests = 0;   // bumped by the tests only
    int                  hold_served   = 0;   // receiver's copy
    int                  hold_cycles   = 0;

    rans64_encoder_step_core uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Works out the words one accepted request emits and advances the shadow state.
    // Products and the update wrap at 64 bits, as the datapath does.
    function automatic void predict_emitted_words(input logic [1:0] op,
                                                  input logic [FREQ_W-1:0] freq,
                                                  input logic [START_W-1:0] start);
        logic [STATE_W-1:0] x;
        logic [STATE_W-1:0] f64;
        logic [STATE_W-1:0] bound;
        x   = shadow_state;
        f64 = {32'd0, freq};
        case (op)
            OP_ENCODE:
            begin
                if (freq != '0)
                begin
                    bound = f64 * (({32'd0, shadow_lb} >> shadow_scale) << WORD_W);
                    if (x >= bound)
                    begin
                        pending_words.push_back('{word: x[WORD_W-1:0], last: 1'b1});
                        x = x >> WORD_W;
                    end
                    shadow_state = ((x / f64) << shadow_scale) + {33'd0, start} + (x % f64);
                end
            end
            OP_FLUSH:
            begin
                pending_words.push_back('{word: x[63:32], last: 1'b0});
                pending_words.push_back('{word: x[31:0], last: 1'b1});
            end
            OP_RESTART:
                shadow_state = {32'd0, shadow_lb};
            default: ;  // unused opcode: dropped
        endcase
    endfunction

    // Offers one request; entered and left at a falling edge, tvalid left high so
    // back-to-back requests need no second assignment in one step.
    task automatic send_request(input logic [1:0] op, input logic [FREQ_W-1:0] freq,
                                input logic [START_W-1:0] start);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {1'b0, start, freq};
        do
            @(posedge clk);
        while (!s_tready);
        predict_emitted_words(op, freq, start);
        @(negedge clk);
    endtask

    // Drops tvalid and waits until every expected word is out, plus the run-out of
    // any encode still in the divider.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_words.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Write, then read the register back before the bus goes idle.
    task automatic write_register(input logic [ADDR_W-1:0] addr, input logic [31:0] value);
        logic [31:0] want;
        want = (addr == ADDR_SCALE) ? {{(32-SCALE_W){1'b0}}, value[SCALE_W-1:0]} : value;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (addr == ADDR_SCALE)
            shadow_scale = value[SCALE_W-1:0];
        else
            shadow_lb = value;
        @(negedge clk);
        if (prdata !== want)
        begin
            $error("prdata: expected %h, got %h", want, prdata);
            fail_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    // Encode with a frequency and start that fit the current scale; half the time a
    // small frequency so the state grows fast and words get pushed out.
    task automatic send_fitting_encode();
        logic [31:0] total;
        logic [31:0] freq;
        logic [31:0] start;
        total = 32'd1 << shadow_scale;
        if ($urandom_range(1) == 0)
            freq = $urandom_range(1, total);
        else
            freq = $urandom_range(1, (total < 16) ? total : 16);
        start = $urandom_range(0, total - freq);
        send_request(OP_ENCODE, freq, start[START_W-1:0]);
    endtask

    // Mostly whole messages (restart, encodes, flush), the rest raw noise.
    // Only requests the core acts on count towards n_items.
    task automatic run_random_traffic(input int n_items);
        int          sent;
        int          len;
        logic [1:0]  op;
        logic [31:0] freq;
        logic [31:0] start;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(99) < 85)
            begin
                start = $urandom();
                send_request(OP_RESTART, $urandom(), start[START_W-1:0]);
                len = $urandom_range(1, 12);
                repeat (len) send_fitting_encode();
                start = $urandom();
                send_request(OP_FLUSH, $urandom(), start[START_W-1:0]);
                sent += len + 2;
            end
            else
            begin
                op    = 2'($urandom_range(3));
                freq  = ($urandom_range(3) == 0) ? 32'd0 : $urandom();
                start = $urandom();
                send_request(op, freq, start[START_W-1:0]);
                if (op != OP_UNUSED && !(op == OP_ENCODE && freq == '0))
                    sent++;
            end
        end
    endtask

    // Extremes of every field, each opcode, dropped requests, wrapping bound product.
    task automatic test_directed();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        send_request(OP_FLUSH, 32'd0, 31'd0);                 // reset state out
        send_request(OP_ENCODE, 32'd1, 31'h0000_FFFF);
        send_request(OP_ENCODE, 32'd1, 31'd0);                // crosses the bound
        send_request(OP_ENCODE, 32'h0001_0000, 31'd0);        // full-scale frequency
        send_request(OP_ENCODE, 32'd0, 31'd5);                // zero frequency, dropped
        send_request(OP_UNUSED, 32'hA5A5_5A5A, 31'h2AAA_AAAA); // dropped
        send_request(OP_ENCODE, 32'hFFFF_FFFF, 31'h7FFF_FFFF); // bound wraps
        send_request(OP_FLUSH, 32'hFFFF_FFFF, 31'h7FFF_FFFF);
        send_request(OP_RESTART, 32'h5555_5555, 31'h5555_5555);
        send_request(OP_FLUSH, 32'd0, 31'd0);
        wait_idle();
        write_register(ADDR_SCALE, 32'd31);
        send_request(OP_ENCODE, 32'h8000_0000, 31'd0);
        send_request(OP_ENCODE, 32'd1, 31'h7FFF_FFFE);
        send_request(OP_ENCODE, 32'd3, 31'd5);
        send_request(OP_FLUSH, 32'd0, 31'd0);
        wait_idle();
        write_register(ADDR_SCALE, 32'd1);
        send_request(OP_ENCODE, 32'd1, 31'd1);
        send_request(OP_ENCODE, 32'd2, 31'd0);
        repeat (3) send_request(OP_ENCODE, 32'd1, 31'd1);
        send_request(OP_FLUSH, 32'd0, 31'd0);
        wait_idle();
    endtask

    // One idling phase, scale changed between chunks; 1 and 31 always visited.
    task automatic test_random_phase(input int unsigned src_pct, input int unsigned sink_pct,
                                     input int n_items);
        int chunk;
        int scale_pick;
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        chunk = 0;
        while (chunk * 85 < n_items)
        begin
            case (chunk % 4)
                0:       scale_pick = 1;
                1:       scale_pick = 31;
                2:       scale_pick = int'(SCALE_RESET);
                default: scale_pick = $urandom_range(2, 30);
            endcase
            wait_idle();
            write_register(ADDR_SCALE, scale_pick);
            write_register(ADDR_LB, LB_RESET);
            run_random_traffic(85);
            chunk++;
        end
        wait_idle();
    endtask

    // Registers outside their usual range are used as written.
    task automatic test_odd_registers();
        src_idle_pct   = 10;
        sink_stall_pct = 10;
        write_register(ADDR_SCALE, 32'd0);
        run_random_traffic(20);
        wait_idle();
        write_register(ADDR_SCALE, 32'(SCALE_RESET));
        write_register(ADDR_LB, 32'd0);            // bound zero: every encode emits
        run_random_traffic(20);
        wait_idle();
        write_register(ADDR_LB, 32'hFFFF_FFFF);
        run_random_traffic(20);
        wait_idle();
        write_register(ADDR_LB, 32'd1);
        run_random_traffic(20);
        wait_idle();
        write_register(ADDR_LB, LB_RESET);
    endtask

    // Receiver holds off for a long stretch while requests keep coming, so the
    // output register fills and the core stops taking requests.
    task automatic test_output_backpressure();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        hold_requests++;
        repeat (3) send_request(OP_FLUSH, 32'd0, 31'd0);
        repeat (4) send_request(OP_ENCODE, 32'd1, 31'h7FFF_FFFF);
        repeat (3) send_request(OP_FLUSH, 32'd0, 31'd0);
        wait_idle();
    endtask

    // receiver: long hold-off when asked, else random stalls
    always @(negedge clk)
    begin
        if (hold_requests != hold_served)
        begin
            hold_served <= hold_requests;
            hold_cycles <= HOLD_CYCLES;
            m_tready    <= 1'b0;
        end
        else if (hold_cycles > 0)
        begin
            m_tready    <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end
        else
            m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // every word taken is checked against the oldest expectation
    always @(posedge clk)
    begin : check_words
        emitted_word_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_words.size() == 0)
            begin
                $error("out_word: unexpected word %h (is_last %b)", m_tdata, m_tlast);
                fail_count++;
            end
            else
            begin
                want = pending_words.pop_front();
                if (m_tdata !== want.word)
                begin
                    $error("out_word: expected %h, got %h", want.word, m_tdata);
                    fail_count++;
                end
                if (m_tlast !== want.last)
                begin
                    $error("is_last: expected %b, got %b", want.last, m_tlast);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed();
        test_random_phase(0, 0, 340);
        test_random_phase(82, 0, 340);
        test_random_phase(0, 82, 340);
        test_random_phase(35, 35, 340);
        test_odd_registers();
        test_output_backpressure();
        wait_idle();
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // watchdog: far beyond the slowest correct run
    initial
    begin
        #15_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
